[src/mbp_pkg.sv]
`timescale 1ns / 1ps
package mbp_pkg;
    localparam int BufferBytes = 80;
    localparam int CellCount = 16;
    localparam int TempCount = 4;

    localparam logic [1:0] KIND_REQ = 2'd0;
    localparam logic [1:0] KIND_VOLT = 2'd1;
    localparam logic [1:0] KIND_TEMP = 2'd2;
    localparam logic [1:0] KIND_STATS = 2'd3;

    localparam logic [1:0] REG_ADDR = 2'd0;
    localparam logic [1:0] REG_VSTEP = 2'd1;
    localparam logic [1:0] REG_SSTEP = 2'd2;
    localparam logic [1:0] REG_SHOLD = 2'd3;

    localparam logic [2:0] SLOT_CELLS = 3'd1;
    localparam logic [2:0] SLOT_STATS = 3'd3;
    localparam logic [2:0] SLOT_CYCLES = 3'd4;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [2:0] next_slot(input logic [2:0] s);
        logic [2:0] r;
        unique case (s)
            3'd1, 3'd2: r = 3'd3;
            3'd3: r = 3'd4;
            default: r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] req_b2(input logic [2:0] s);
        return (s == 3'd0) ? 8'hF8 : 8'h13;
    endfunction

    function automatic logic [7:0] req_b3(input logic [2:0] s);
        logic [7:0] r;
        unique case (s)
            3'd0: r = 8'h0B;
            3'd1: r = 8'h2A;
            3'd2: r = 8'h1C;
            3'd3: r = 8'h02;
            3'd4: r = 8'h00;
            3'd5: r = 8'h20;
            default: r = 8'h40;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] req_b5(input logic [2:0] s);
        logic [7:0] r;
        unique case (s)
            3'd0: r = 8'h01;
            3'd1: r = 8'h18;
            3'd2: r = 8'h04;
            3'd3: r = 8'h0A;
            3'd6: r = 8'h0A;
            default: r = 8'h20;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        end
        return x;
    endfunction
endpackage

[src/mbp_ram.sv]
`timescale 1ns / 1ps
module mbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[src/mbp_front.sv]
`timescale 1ns / 1ps
module mbp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  mbp_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output mbp_pkg::t_cmd o_cmd,
    input  logic          i_take
);
    // two-entry queue between accept side and the executor
    mbp_pkg::t_cmd r_q [2];
    logic          r_rd;
    logic          r_wr;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_q[r_wr] <= i_cmd;
                r_wr      <= ~r_wr;
            end
            if (i_take && o_valid) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_take && o_valid};
        end
    end
endmodule

[src/mbp_back.sv]
`timescale 1ns / 1ps
module mbp_back #(
    parameter int BUFFER_BYTES = mbp_pkg::BufferBytes,
    parameter int CELL_COUNT = mbp_pkg::CellCount,
    parameter int TEMP_COUNT = mbp_pkg::TempCount
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  mbp_pkg::t_cmd      i_cmd,
    output logic               o_take,
    input  logic [7:0]         i_slave_address,
    input  logic [15:0]        i_voltage_step_limit,
    input  logic [6:0]         i_soc_step_limit,
    input  logic [3:0]         i_soc_hold_limit,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_tx_byte,
    output logic [3:0]         o_item_index,
    output logic [15:0]        o_item_value,
    output logic [15:0]        o_voltage_cv,
    output logic signed [16:0] o_current_da,
    output logic signed [7:0]  o_charge_state,
    output logic signed [7:0]  o_bms_temp,
    output logic signed [7:0]  o_cycle_count,
    output logic               o_last
);
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_CAP, S_EMIT_REC, S_PARSE, S_STATS,
        S_REQ, S_CLEAR
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [7:0]    r_addr;
    logic [7:0]    r_b0;
    logic          r_hi;
    logic [4:0]    r_rec;
    logic [2:0]    r_slot;
    logic [2:0]    r_req;
    logic [15:0]   r_crc;
    logic [15:0]   r_volt;
    logic signed [16:0] r_cur;
    logic signed [7:0]  r_soc;
    logic [3:0]    r_rej;
    logic signed [7:0]  r_cyc;
    logic signed [7:0]  r_tmp;
    logic [AW-1:0] r_clr;
    logic [7:0]    r_sb [5];
    logic [2:0]    r_sx;
    logic          r_empty_n;

    logic [7:0]    w_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [7:0]    w_byte;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = i_cmd.data;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = 8'd0;
        end else if (r_state == S_IDLE && i_valid && !i_cmd.op
                     && r_count < CW'(BUFFER_BYTES)) begin
            w_we = 1'b1;
        end
    end

    mbp_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_addr[AW-1:0]),
        .o_rdata(w_rdata)
    );

    // bytes past the buffer read as zero
    assign w_byte = ({1'b0, r_addr} < 9'(BUFFER_BYTES)) ? w_rdata : 8'd0;
    assign o_take = (r_state == S_IDLE) && i_valid && (!i_cmd.op || o_empty);

    // stats byte fetch list: 11,12,13,14,20,22 handled via small sequence
    function automatic logic [7:0] stat_addr(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd0: r = 8'd11;
            3'd1: r = 8'd12;
            3'd2: r = 8'd13;
            3'd3: r = 8'd14;
            3'd4: r = 8'd20;
            default: r = 8'd22;
        endcase
        return r;
    endfunction

    logic [7:0]  w_req_byte;
    logic [15:0] w_v;
    logic [16:0] w_dv;
    logic signed [9:0]  w_h;
    logic signed [16:0] w_curn;
    logic signed [8:0]  w_ds;
    logic [7:0]  w_ads;
    logic signed [8:0]  w_dc;

    always_comb begin
        unique case (r_req)
            3'd0: w_req_byte = i_slave_address;
            3'd1: w_req_byte = 8'd3;
            3'd2: w_req_byte = mbp_pkg::req_b2(r_slot);
            3'd3: w_req_byte = mbp_pkg::req_b3(r_slot);
            3'd4: w_req_byte = 8'd0;
            3'd5: w_req_byte = mbp_pkg::req_b5(r_slot);
            3'd6: w_req_byte = r_crc[7:0];
            default: w_req_byte = r_crc[15:8];
        endcase
        w_v    = {r_sb[0], r_sb[1]};
        w_dv   = (r_volt >= w_v) ? {1'b0, r_volt - w_v} : {1'b0, w_v - r_volt};
        w_h    = (r_sb[2] >= 8'd254) ? $signed({2'b11, r_sb[2]}) : $signed({2'b00, r_sb[2]});
        w_curn = 17'(w_h * $signed(10'sd255));
        w_curn = -w_curn - $signed({9'd0, r_sb[3]});
        w_ds   = 9'(r_soc) - 9'($signed(w_byte));
        w_ads  = w_ds[8] ? 8'(-w_ds) : w_ds[7:0];
        w_dc   = 9'($signed(w_byte)) - 9'(r_cyc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_count <= '0;
            r_slot  <= mbp_pkg::SLOT_STATS;
            r_volt  <= 16'd4800;
            r_cur   <= '0;
            r_soc   <= 8'sd99;
            r_rej   <= '0;
            r_cyc   <= '0;
            r_tmp   <= '0;
            r_clr   <= '0;
            r_empty_n <= 1'b0;
        end else begin
            if (i_pop && r_empty_n) begin
                r_empty_n <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        if (!i_cmd.op) begin
                            if (r_count < CW'(BUFFER_BYTES)) r_count <= r_count + 1'b1;
                        end else begin
                            r_rec <= '0;
                            r_hi  <= 1'b1;
                            r_sx  <= '0;
                            if (r_slot == mbp_pkg::SLOT_CELLS) begin
                                r_addr  <= 8'd3;
                                r_state <= S_RD;
                            end else if (r_slot == mbp_pkg::SLOT_STATS) begin
                                r_addr  <= 8'd11;
                                r_state <= S_PARSE;
                            end else if (r_slot == mbp_pkg::SLOT_CYCLES) begin
                                r_addr  <= 8'd30;
                                r_state <= S_PARSE;
                            end else begin
                                r_state <= S_STATS;
                            end
                        end
                    end
                end
                S_RD: r_state <= S_WAIT;
                S_WAIT: begin
                    if (r_hi) begin
                        r_b0    <= w_byte;
                        r_hi    <= 1'b0;
                        r_addr  <= r_addr + 8'd1;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_CAP;
                    end
                end
                S_CAP: begin
                    if (!r_empty_n) begin
                        r_empty_n <= 1'b1;
                        o_kind <= (r_rec < 5'(CELL_COUNT)) ? mbp_pkg::KIND_VOLT
                                                            : mbp_pkg::KIND_TEMP;
                        o_item_index <= (r_rec < 5'(CELL_COUNT)) ? r_rec[3:0]
                                                                  : 4'(r_rec - 5'(CELL_COUNT));
                        o_item_value <= {r_b0, w_byte};
                        o_tx_byte <= '0; o_voltage_cv <= '0; o_current_da <= '0;
                        o_charge_state <= '0; o_bms_temp <= '0; o_cycle_count <= '0;
                        o_last <= 1'b0;
                        r_rec <= r_rec + 5'd1;
                        r_hi  <= 1'b1;
                        if (r_rec + 5'd1 == 5'(CELL_COUNT + TEMP_COUNT)) begin
                            r_state <= S_STATS;
                        end else begin
                            r_addr  <= (r_rec + 5'd1 == 5'(CELL_COUNT)) ? 8'd35
                                                                        : r_addr + 8'd1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_PARSE: begin
                    // fetch wait tracked by r_hi, which toggles between a wait pass and a capture pass
                    if (r_hi) begin
                        r_hi <= 1'b0;
                    end else begin
                        r_hi <= 1'b1;
                        if (r_slot == mbp_pkg::SLOT_CYCLES) begin
                            if (w_byte != 8'd0 || w_dc == 9'sd0 || w_dc == 9'sd1
                                || w_dc == -9'sd1) begin
                                r_cyc <= w_byte;
                            end
                            r_state <= S_STATS;
                        end else if (r_sx == 3'd5) begin
                            if (w_v != 16'd0 && w_dv < {1'b0, i_voltage_step_limit})
                                r_volt <= w_v;
                            r_cur <= w_curn;
                            r_tmp <= r_sb[4];
                            if (w_ads < {1'b0, i_soc_step_limit} || r_rej >= i_soc_hold_limit) begin
                                r_soc <= w_byte;
                                r_rej <= '0;
                            end else begin
                                r_rej <= r_rej + 4'd1;
                            end
                            r_state <= S_STATS;
                        end else begin
                            r_sb[r_sx] <= w_byte;
                            r_sx   <= r_sx + 3'd1;
                            r_addr <= stat_addr(r_sx + 3'd1);
                        end
                    end
                end
                S_STATS: begin
                    if (!r_empty_n) begin
                        r_empty_n <= 1'b1;
                        o_kind <= mbp_pkg::KIND_STATS;
                        o_tx_byte <= '0; o_item_index <= '0; o_item_value <= '0;
                        o_voltage_cv <= r_volt; o_current_da <= r_cur;
                        o_charge_state <= r_soc; o_bms_temp <= r_tmp;
                        o_cycle_count <= r_cyc; o_last <= 1'b0;
                        r_slot <= mbp_pkg::next_slot(r_slot);
                        r_req  <= '0;
                        r_crc  <= 16'hFFFF;
                        r_state <= S_REQ;
                    end
                end
                S_REQ: begin
                    if (!r_empty_n) begin
                        r_empty_n <= 1'b1;
                        o_kind <= mbp_pkg::KIND_REQ;
                        o_tx_byte <= w_req_byte;
                        o_item_index <= '0; o_item_value <= '0;
                        o_voltage_cv <= '0; o_current_da <= '0;
                        o_charge_state <= '0; o_bms_temp <= '0; o_cycle_count <= '0;
                        o_last <= (r_req == 3'd7);
                        if (r_req < 3'd6) r_crc <= mbp_pkg::crc_byte(r_crc, w_req_byte);
                        r_req <= r_req + 3'd1;
                        if (r_req == 3'd7) begin
                            r_clr   <= '0;
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(BUFFER_BYTES - 1)) begin
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty = !r_empty_n;

`ifndef NO_ASSERTIONS
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_BYTES)) else $error("count overflow");
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot == 3'd1 || r_slot == 3'd3 || r_slot == 3'd4) else $error("bad slot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty_n && !i_pop |=> r_empty_n && $stable(o_tx_byte)) else $error("lost result");
`endif
endmodule

[src/modbus_bms_poller_core.sv]
`timescale 1ns / 1ps
// Modbus-RTU poller for a battery management system. Received bytes are taken
// one per cycle, while the back end is idle, into an on-chip response buffer
// through a two-entry queue. A poll tick waits until the result port is empty and
// then runs the back end: a command 1 parse emits 20 records (16 cell voltages and
// 4 temperatures), each read as two buffer bytes; a command 3 parse reads six bytes
// and a command 4 parse one byte; then the stats record and 8 request bytes go out,
// each once the result side has popped the one before, and a clearing pass zeroes
// the buffer. The same clearing pass runs after reset, so input is held off until
// it is done.
module modbus_bms_poller_core #(
    parameter int BUFFER_BYTES = mbp_pkg::BufferBytes,
    parameter int CELL_COUNT = mbp_pkg::CellCount,
    parameter int TEMP_COUNT = mbp_pkg::TempCount
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_operation,
    input  logic [7:0]         i_rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_tx_byte,
    output logic [3:0]         o_item_index,
    output logic [15:0]        o_item_value,
    output logic [15:0]        o_voltage_cv,
    output logic signed [16:0] o_current_da,
    output logic signed [7:0]  o_charge_state,
    output logic signed [7:0]  o_bms_temp,
    output logic signed [7:0]  o_cycle_count,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    logic [7:0]  r_addr;
    logic [15:0] r_vstep;
    logic [6:0]  r_sstep;
    logic [3:0]  r_shold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= 8'd1;
            r_vstep <= 16'd1000;
            r_sstep <= 7'd5;
            r_shold <= 4'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbp_pkg::REG_ADDR:  r_addr  <= i_cfg_data[7:0];
                mbp_pkg::REG_VSTEP: r_vstep <= i_cfg_data;
                mbp_pkg::REG_SSTEP: r_sstep <= i_cfg_data[6:0];
                mbp_pkg::REG_SHOLD: r_shold <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    mbp_pkg::t_cmd w_in;
    mbp_pkg::t_cmd w_q;
    logic          w_valid;
    logic          w_take;

    assign w_in.op   = i_operation;
    assign w_in.data = i_rx_byte;

    mbp_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_cmd  (w_in),
        .o_valid(w_valid),
        .o_cmd  (w_q),
        .i_take (w_take)
    );

    mbp_back #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .CELL_COUNT  (CELL_COUNT),
        .TEMP_COUNT  (TEMP_COUNT)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (w_valid),
        .i_cmd               (w_q),
        .o_take              (w_take),
        .i_slave_address     (r_addr),
        .i_voltage_step_limit(r_vstep),
        .i_soc_step_limit    (r_sstep),
        .i_soc_hold_limit    (r_shold),
        .o_empty             (empty),
        .i_pop               (pop),
        .o_kind              (o_kind),
        .o_tx_byte           (o_tx_byte),
        .o_item_index        (o_item_index),
        .o_item_value        (o_item_value),
        .o_voltage_cv        (o_voltage_cv),
        .o_current_da        (o_current_da),
        .o_charge_state      (o_charge_state),
        .o_bms_temp          (o_bms_temp),
        .o_cycle_count       (o_cycle_count),
        .o_last              (o_last)
    );
endmodule
